// ===== rtl/pvt_pkg.sv =====
// Shared types and constants for the perspective vertex transform.
// Used by pvt_div_pipe and perspective_vertex_transform; no dependencies.
`default_nettype none

package pvt_pkg;

    // Data path widths.
    localparam int unsigned COORD_W = 16;
    localparam int unsigned ACC_W   = 32;
    localparam int unsigned COEFF_N = 4;
    localparam int unsigned ROW_W   = COORD_W * COEFF_N;
    localparam int unsigned FRAC_W  = 6;
    localparam int unsigned IDX_W   = 2;

    // Screen mapping constants.
    localparam logic signed [ACC_W-1:0] SCREEN_CENTER = 32'sd64;
    localparam logic signed [ACC_W-1:0] SCREEN_SCALE  = 32'sd120;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_ROW0 = 2'd0;
    localparam logic [IDX_W-1:0] REG_ROW1 = 2'd1;
    localparam logic [IDX_W-1:0] REG_ROW2 = 2'd2;
    localparam logic [IDX_W-1:0] REG_MODE = 2'd3;

    // Reset values form the identity matrix in Q6.
    localparam logic [ROW_W-1:0] ROW0_RESET = 64'h0000_0000_0000_0040;
    localparam logic [ROW_W-1:0] ROW1_RESET = 64'h0000_0000_0040_0000;
    localparam logic [ROW_W-1:0] ROW2_RESET = 64'h0000_0040_0000_0000;

    typedef struct packed {
        logic signed [COORD_W-1:0] vx;
        logic signed [COORD_W-1:0] vy;
        logic signed [COORD_W-1:0] vz;
    } vertex_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
        logic                      divide_by_zero;
    } result_t;

    // Side information that travels alongside the divider stages.
    typedef struct packed {
        logic                      zero;
        logic                      neg_x;
        logic                      neg_y;
        logic signed [ACC_W-1:0]   z;
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
    } div_tag_t;

endpackage

`default_nettype wire

// ===== rtl/pvt_div_pipe.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Divides two numerators by a shared denominator; depends on pvt_pkg.
`default_nettype none

module pvt_div_pipe #(
    parameter int unsigned WIDTH = pvt_pkg::ACC_W
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    en,
    input  wire                    in_valid,
    input  wire  [WIDTH-1:0]       in_num_x,
    input  wire  [WIDTH-1:0]       in_num_y,
    input  wire  [WIDTH-1:0]       in_den,
    input  pvt_pkg::div_tag_t      in_tag,
    output logic                   out_valid,
    output logic [WIDTH-1:0]       out_quo_x,
    output logic [WIDTH-1:0]       out_quo_y,
    output pvt_pkg::div_tag_t      out_tag
);

    logic                    valid_reg [WIDTH];
    logic [WIDTH-1:0]        remx_reg  [WIDTH];
    logic [WIDTH-1:0]        remy_reg  [WIDTH];
    logic [WIDTH-1:0]        numx_reg  [WIDTH];
    logic [WIDTH-1:0]        numy_reg  [WIDTH];
    logic [WIDTH-1:0]        quox_reg  [WIDTH];
    logic [WIDTH-1:0]        quoy_reg  [WIDTH];
    logic [WIDTH-1:0]        den_reg   [WIDTH];
    pvt_pkg::div_tag_t       tag_reg   [WIDTH];

    genvar k;
    generate
        for (k = 0; k < WIDTH; k++) begin : g_stage
            logic              v_in;
            logic [WIDTH-1:0]  rx_in, ry_in, nx_in, ny_in, qx_in, qy_in, d_in;
            pvt_pkg::div_tag_t t_in;
            logic [WIDTH-1:0]  tx, ty;
            logic [WIDTH:0]    dx, dy;

            // Stage inputs come from the port or from the previous stage.
            if (k == 0) begin : g_first
                assign v_in  = in_valid;
                assign rx_in = '0;
                assign ry_in = '0;
                assign nx_in = in_num_x;
                assign ny_in = in_num_y;
                assign qx_in = '0;
                assign qy_in = '0;
                assign d_in  = in_den;
                assign t_in  = in_tag;
            end else begin : g_rest
                assign v_in  = valid_reg[k-1];
                assign rx_in = remx_reg[k-1];
                assign ry_in = remy_reg[k-1];
                assign nx_in = numx_reg[k-1];
                assign ny_in = numy_reg[k-1];
                assign qx_in = quox_reg[k-1];
                assign qy_in = quoy_reg[k-1];
                assign d_in  = den_reg[k-1];
                assign t_in  = tag_reg[k-1];
            end

            // Bring down the next numerator bit and try the subtraction.
            assign tx = {rx_in[WIDTH-2:0], nx_in[WIDTH-1]};
            assign ty = {ry_in[WIDTH-2:0], ny_in[WIDTH-1]};
            assign dx = {1'b0, tx} - {1'b0, d_in};
            assign dy = {1'b0, ty} - {1'b0, d_in};

            // Valid bit of this stage.
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[k] <= 1'b0;
                end else if (en) begin
                    valid_reg[k] <= v_in;
                end
            end

            // Partial remainder, quotient and side data of this stage.
            always_ff @(posedge aclk) begin
                if (en) begin
                    remx_reg[k] <= dx[WIDTH] ? tx : dx[WIDTH-1:0];
                    remy_reg[k] <= dy[WIDTH] ? ty : dy[WIDTH-1:0];
                    quox_reg[k] <= {qx_in[WIDTH-2:0], ~dx[WIDTH]};
                    quoy_reg[k] <= {qy_in[WIDTH-2:0], ~dy[WIDTH]};
                    numx_reg[k] <= {nx_in[WIDTH-2:0], 1'b0};
                    numy_reg[k] <= {ny_in[WIDTH-2:0], 1'b0};
                    den_reg[k]  <= d_in;
                    tag_reg[k]  <= t_in;
                end
            end
        end
    endgenerate

    assign out_valid = valid_reg[WIDTH-1];
    assign out_quo_x = quox_reg[WIDTH-1];
    assign out_quo_y = quoy_reg[WIDTH-1];
    assign out_tag   = tag_reg[WIDTH-1];

    // A stalled pipeline keeps its valid bits.
    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(out_valid) && $stable(valid_reg[0]))
        else $error("divider valid bits moved during a stall");

    // A transaction leaving the last stage entered the one before it earlier.
    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        en && !valid_reg[WIDTH-2] |=> !out_valid)
        else $error("divider produced a transaction from an empty stage");

endmodule

`default_nettype wire

// ===== rtl/perspective_vertex_transform.sv =====
// Top level of the perspective vertex transform: matrix rows, divider, screen mapping.
// Depends on pvt_pkg and pvt_div_pipe.
//
// A vertex arrives on the s_ channel (s_valid/s_ready/s_vertex) and one result
// leaves on the m_ channel (m_valid/m_ready/m_result) for every vertex, in order.
// The matrix rows and the mode are set through cfg_we/cfg_index/cfg_wdata; the
// user must do so only while no transaction is in flight (the block does not
// enforce it); they take effect for the next vertex. One vertex enters per cycle
// unless held. Registers: stage M (products), S (row sums), C (sign handling),
// divider stages (one quotient bit each), P1 to P3 (screen mapping and output).
// When m_ready is low with a result waiting, the whole pipeline holds and
// s_ready drops; nothing is lost or repeated. Empty stages inside the pipeline
// hold too, so a bubble stays in place until the receiver takes the result.
// Reset clears all valid bits and loads the identity matrix in perspective mode.
`default_nettype none

module perspective_vertex_transform (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           cfg_we,
    input  wire  [pvt_pkg::IDX_W-1:0]     cfg_index,
    input  wire  [pvt_pkg::ROW_W-1:0]     cfg_wdata,
    input  wire                           s_valid,
    output logic                          s_ready,
    input  pvt_pkg::vertex_t              s_vertex,
    output logic                          m_valid,
    input  wire                           m_ready,
    output pvt_pkg::result_t              m_result
);

    localparam int unsigned CW = pvt_pkg::COORD_W;
    localparam int unsigned AW = pvt_pkg::ACC_W;
    localparam int unsigned FW = pvt_pkg::FRAC_W;

    // Truncating division by 64.
    function automatic logic signed [AW-1:0] div64(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] b;
        b = v[AW-1] ? v + 32'sd63 : v;
        return b >>> FW;
    endfunction

    logic [pvt_pkg::ROW_W-1:0] row_reg [3];
    logic                      mode_reg;
    logic                      adv;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg[0] <= pvt_pkg::ROW0_RESET;
            row_reg[1] <= pvt_pkg::ROW1_RESET;
            row_reg[2] <= pvt_pkg::ROW2_RESET;
            mode_reg   <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                pvt_pkg::REG_ROW0: row_reg[0] <= cfg_wdata;
                pvt_pkg::REG_ROW1: row_reg[1] <= cfg_wdata;
                pvt_pkg::REG_ROW2: row_reg[2] <= cfg_wdata;
                pvt_pkg::REG_MODE: mode_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // The pipeline moves whenever the output register is free or being drained.
    logic m_valid_reg;
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // Stage M: nine products and the translation column.
    logic                 vm_reg;
    logic signed [AW-1:0] prod_reg  [3][3];
    logic signed [CW-1:0] trans_reg [3];
    logic signed [CW-1:0] vin [3];

    assign vin[0] = s_vertex.vx;
    assign vin[1] = s_vertex.vy;
    assign vin[2] = s_vertex.vz;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vm_reg <= 1'b0;
        end else if (adv) begin
            vm_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    prod_reg[r][c] <= AW'(vin[c] * $signed(row_reg[r][CW*c +: CW]));
                end
                trans_reg[r] <= $signed(row_reg[r][CW*3 +: CW]);
            end
        end
    end

    // Stage S: row sums, wrapping at 32 bits.
    logic                 vs_reg;
    logic signed [AW-1:0] sum_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vs_reg <= 1'b0;
        end else if (adv) begin
            vs_reg <= vm_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int r = 0; r < 3; r++) begin
                sum_reg[r] <= prod_reg[r][0] + prod_reg[r][1] + prod_reg[r][2]
                              + AW'(trans_reg[r]);
            end
        end
    end

    // Stage C: scale numerators, take magnitudes and signs for the divider.
    logic                 vc_reg;
    logic [AW-1:0]        numx_reg, numy_reg, den_reg;
    pvt_pkg::div_tag_t    tagc_reg;
    logic signed [AW-1:0] shx, shy, zs;

    assign shx = sum_reg[0] <<< FW;
    assign shy = sum_reg[1] <<< FW;
    assign zs  = sum_reg[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= 1'b0;
        end else if (adv) begin
            vc_reg <= vs_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            numx_reg       <= shx[AW-1] ? AW'(-shx) : shx;
            numy_reg       <= shy[AW-1] ? AW'(-shy) : shy;
            den_reg        <= zs[AW-1] ? AW'(-zs) : zs;
            tagc_reg.zero  <= (zs == '0);
            tagc_reg.neg_x <= shx[AW-1] ^ zs[AW-1];
            tagc_reg.neg_y <= shy[AW-1] ^ zs[AW-1];
            tagc_reg.z     <= zs;
            tagc_reg.ax    <= sum_reg[0][FW +: CW];
            tagc_reg.ay    <= sum_reg[1][FW +: CW];
        end
    end

    // Stage D: pipelined divider.
    logic              vd;
    logic [AW-1:0]     qx, qy;
    pvt_pkg::div_tag_t tagd;

    pvt_div_pipe #(
        .WIDTH (AW)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (adv),
        .in_valid  (vc_reg),
        .in_num_x  (numx_reg),
        .in_num_y  (numy_reg),
        .in_den    (den_reg),
        .in_tag    (tagc_reg),
        .out_valid (vd),
        .out_quo_x (qx),
        .out_quo_y (qy),
        .out_tag   (tagd)
    );

    // Stage P1: restore quotient signs and center on the screen.
    logic                 vp1_reg;
    logic signed [AW-1:0] sx_reg, sy_reg;
    pvt_pkg::div_tag_t    tag1_reg;
    logic signed [AW-1:0] qxs, qys;

    assign qxs = tagd.neg_x ? AW'(-qx) : qx;
    assign qys = tagd.neg_y ? AW'(-qy) : qy;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vp1_reg <= 1'b0;
        end else if (adv) begin
            vp1_reg <= vd;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sx_reg   <= qxs + pvt_pkg::SCREEN_CENTER;
            sy_reg   <= pvt_pkg::SCREEN_CENTER - qys;
            tag1_reg <= tagd;
        end
    end

    // Stage P2: screen scaling.
    logic                 vp2_reg;
    logic signed [AW-1:0] px_reg, py_reg;
    pvt_pkg::div_tag_t    tag2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vp2_reg <= 1'b0;
        end else if (adv) begin
            vp2_reg <= vp1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            px_reg   <= sx_reg * pvt_pkg::SCREEN_SCALE;
            py_reg   <= sy_reg * pvt_pkg::SCREEN_SCALE;
            tag2_reg <= tag1_reg;
        end
    end

    // Stage P3: final divide by 64, mode selection and the output register.
    pvt_pkg::result_t     m_result_reg, m_result_next;
    logic signed [AW-1:0] ox, oy, oz;

    assign ox = div64(px_reg);
    assign oy = div64(py_reg);
    assign oz = div64(tag2_reg.z);

    always_comb begin
        m_result_next = '0;
        if (!mode_reg) begin
            m_result_next.out_x = tag2_reg.ax;
            m_result_next.out_y = tag2_reg.ay;
            m_result_next.out_z = tag2_reg.z[FW +: CW];
        end else if (tag2_reg.zero) begin
            m_result_next.divide_by_zero = 1'b1;
        end else begin
            m_result_next.out_x = ox[CW-1:0];
            m_result_next.out_y = oy[CW-1:0];
            m_result_next.out_z = oz[CW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= vp2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_result_reg <= m_result_next;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

    // A zero-depth result carries zero coordinates.
    a_zero_outputs: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result.divide_by_zero |->
            m_result.out_x == '0 && m_result.out_y == '0 && m_result.out_z == '0)
        else $error("zero-depth result with nonzero coordinates");

    // The zero-depth flag only arises in perspective mode.
    a_flag_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result.divide_by_zero |-> mode_reg)
        else $error("zero-depth flag raised in affine mode");

    // A transaction reaching the output was in the last scaling stage before.
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(vp2_reg))
        else $error("result appeared without a transaction behind it");

endmodule

`default_nettype wire

// ===== tb/perspective_vertex_transform_tb.sv =====
// Self-checking testbench for perspective_vertex_transform: directed vertices, then random ones,
// each result compared with an in-bench fixed-point transform model.
// Depends on pvt_pkg and the perspective_vertex_transform RTL.
`timescale 1ns / 100ps

module perspective_vertex_transform_tb;

    localparam int LATENCY     = 38;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_N    = 650;

    logic                      aclk;
    logic                      aresetn;
    logic                      cfg_we;
    logic [pvt_pkg::IDX_W-1:0] cfg_index;
    logic [pvt_pkg::ROW_W-1:0] cfg_wdata;
    logic                      s_valid;
    logic                      s_ready;
    pvt_pkg::vertex_t          s_vertex;
    logic                      m_valid;
    logic                      m_ready;
    pvt_pkg::result_t          m_result;

    perspective_vertex_transform dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_vertex(s_vertex),
        .m_valid(m_valid), .m_ready(m_ready), .m_result(m_result)
    );

    // Local copy of the matrix and mode.
    logic [pvt_pkg::ROW_W-1:0] mat_row[3];
    logic                      persp_on;

    pvt_pkg::result_t expected_results[$];
    int               fail_count;
    int               cycle_count;
    bit               stim_done;
    bit               long_holdoff;

    // One directed row: vertex, and optionally a typed-in expected result.
    typedef struct {
        pvt_pkg::vertex_t v;
        bit               has_exp;
        pvt_pkg::result_t exp_r;
    } vertex_row_t;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Signed 16-bit coefficient of a row word.
    function automatic logic signed [31:0] coeff_of(logic [pvt_pkg::ROW_W-1:0] row, int col);
        logic signed [15:0] w;
        w = row[16*col +: 16];
        return 32'(w);
    endfunction

    // Truncating 32-bit divide; most negative by -1 wraps.
    function automatic logic signed [31:0] trunc_div(logic signed [31:0] a,
                                                     logic signed [31:0] b);
        logic signed [63:0] q;
        q = 64'(a) / 64'(b);
        return q[31:0];
    endfunction

    function automatic logic signed [31:0] screen_map(logic signed [31:0] c);
        logic signed [31:0] p;
        p = c * pvt_pkg::SCREEN_SCALE;
        return trunc_div(p, 32'sd64);
    endfunction

    // Transform one vertex with the current matrix and mode.
    function automatic pvt_pkg::result_t transform_vertex(pvt_pkg::vertex_t v);
        pvt_pkg::result_t   r;
        logic signed [31:0] sum[3];
        logic signed [31:0] sx, sy;
        for (int i = 0; i < 3; i++)
            sum[i] = 32'(v.vx) * coeff_of(mat_row[i], 0) + 32'(v.vy) * coeff_of(mat_row[i], 1)
                   + 32'(v.vz) * coeff_of(mat_row[i], 2) + coeff_of(mat_row[i], 3);
        r = '0;
        if (!persp_on) begin
            r.out_x = 16'(sum[0] >>> pvt_pkg::FRAC_W);
            r.out_y = 16'(sum[1] >>> pvt_pkg::FRAC_W);
            r.out_z = 16'(sum[2] >>> pvt_pkg::FRAC_W);
        end else if (sum[2] == 0) begin
            r.divide_by_zero = 1'b1;
        end else begin
            sx = trunc_div(sum[0] <<< pvt_pkg::FRAC_W, sum[2]) + pvt_pkg::SCREEN_CENTER;
            sy = pvt_pkg::SCREEN_CENTER - trunc_div(sum[1] <<< pvt_pkg::FRAC_W, sum[2]);
            r.out_x = 16'(screen_map(sx));
            r.out_y = 16'(screen_map(sy));
            r.out_z = 16'(trunc_div(sum[2], 32'sd64));
        end
        return r;
    endfunction

    task automatic write_reg(logic [pvt_pkg::IDX_W-1:0] idx, logic [pvt_pkg::ROW_W-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            pvt_pkg::REG_ROW0: mat_row[0] = data;
            pvt_pkg::REG_ROW1: mat_row[1] = data;
            pvt_pkg::REG_ROW2: mat_row[2] = data;
            default:           persp_on = data[0];
        endcase
    endtask

    // Stop offering, wait until every result is in, then let the pipeline drain.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
    endtask

    // Offer one vertex after a random gap; queue its expected result at acceptance.
    // Valid stays high after acceptance so that a vertex with no gap follows directly.
    task automatic send_vertex(pvt_pkg::vertex_t v, bit has_exp, pvt_pkg::result_t exp_r);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        if ($urandom_range(0, 1) == 0) gap = 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_vertex <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_results.push_back(has_exp ? exp_r : transform_vertex(v));
        if (has_exp && exp_r !== transform_vertex(v)) begin
            $error("directed row disagrees with predictor for vertex %h", v);
            fail_count++;
        end
        @(negedge aclk);
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(0, 8)) - 16'd4;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [pvt_pkg::ROW_W-1:0] rand_row();
        logic [pvt_pkg::ROW_W-1:0] r;
        for (int c = 0; c < 4; c++)
            r[16*c +: 16] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                       : 16'($urandom_range(0, 256)) - 16'd128;
        return r;
    endfunction

    // Stimulus.
    initial begin
        vertex_row_t      directed[$];
        vertex_row_t      row;
        pvt_pkg::result_t none;
        pvt_pkg::vertex_t v;
        none      = '0;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_vertex  = '0;
        stim_done = 1'b0;
        long_holdoff = 1'b0;
        mat_row[0] = pvt_pkg::ROW0_RESET;
        mat_row[1] = pvt_pkg::ROW1_RESET;
        mat_row[2] = pvt_pkg::ROW2_RESET;
        persp_on   = 1'b1;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // After reset: identity in perspective mode. Zero depth flags.
        directed.push_back('{'{16'sd5, 16'sd7, 16'sd0}, 1'b1, '{16'sd0, 16'sd0, 16'sd0, 1'b1}});
        // z = 64 gives screen (64+x)*120/64 style results; z out = 64.
        directed.push_back('{'{16'sd0, 16'sd0, 16'sd64}, 1'b1,
                             '{16'sd120, 16'sd120, 16'sd64, 1'b0}});
        directed.push_back('{'{16'sh7FFF, 16'sh8000, 16'sd1}, 1'b0, none});
        directed.push_back('{'{16'sh8000, 16'sh7FFF, 16'sh8000}, 1'b0, none});
        directed.push_back('{'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, 1'b0, none});
        directed.push_back('{'{16'sh8000, 16'sh8000, -16'sd1}, 1'b0, none});
        foreach (directed[i]) send_vertex(directed[i].v, directed[i].has_exp, directed[i].exp_r);
        wait_idle();

        // Affine mode: zero depth does not flag.
        write_reg(pvt_pkg::REG_MODE, 64'hFFFF_FFFF_FFFF_FFFE);
        send_vertex('{16'sd0, 16'sd0, 16'sd0}, 1'b1, none);
        send_vertex('{-16'sd1, 16'sd64, 16'sh8000}, 1'b1, '{-16'sd1, 16'sd64, 16'sh8000, 1'b0});
        send_vertex('{16'sh7FFF, 16'sh8000, 16'sh7FFF}, 1'b0, none);
        wait_idle();

        // Extreme coefficients, wrapping sums.
        write_reg(pvt_pkg::REG_ROW0, 64'h8000_8000_8000_8000);
        write_reg(pvt_pkg::REG_ROW1, 64'h7FFF_7FFF_7FFF_7FFF);
        write_reg(pvt_pkg::REG_ROW2, 64'hFFFF_FFFF_FFFF_FFFF);
        send_vertex('{16'sh8000, 16'sh8000, 16'sh8000}, 1'b0, none);
        send_vertex('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF}, 1'b0, none);
        wait_idle();
        // Quotient overflow: X<<6 most negative, Z = -1.
        write_reg(pvt_pkg::REG_MODE, 64'd1);
        write_reg(pvt_pkg::REG_ROW0, {16'h0000, 16'h0000, 16'h0000, 16'h0400});
        write_reg(pvt_pkg::REG_ROW1, {16'h0000, 16'h0000, 16'h0400, 16'h0000});
        write_reg(pvt_pkg::REG_ROW2, {16'hFFFF, 16'h0000, 16'h0000, 16'h0000});
        send_vertex('{16'sh8000, 16'sh8000, 16'sd0}, 1'b0, none);
        send_vertex('{16'sh7FFF, 16'sh8000, 16'sd5}, 1'b0, none);
        wait_idle();

        // Random phases with fresh settings; one holds the receiver off.
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(pvt_pkg::REG_ROW0, rand_row());
            write_reg(pvt_pkg::REG_ROW1, rand_row());
            write_reg(pvt_pkg::REG_ROW2, (ph == 2) ? 64'h0 : rand_row());
            write_reg(pvt_pkg::REG_MODE, 64'($urandom_range(0, 1)));
            if (ph == 3) long_holdoff = 1'b1;
            for (int n = 0; n < RANDOM_N / 6; n++) begin
                v.vx = rand_coord();
                v.vy = rand_coord();
                v.vz = rand_coord();
                if ($urandom_range(0, 9) == 0) v.vz = '0;
                send_vertex(v, 1'b0, none);
            end
            long_holdoff = 1'b0;
            wait_idle();
        end
        stim_done = 1'b1;
    end

    // Receiver: random stalls, and one long hold-off while the sender keeps offering.
    initial begin
        int stall;
        bit did_long;
        m_ready  = 1'b0;
        did_long = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (long_holdoff && !did_long) begin
                did_long = 1'b1;
                m_ready <= 1'b0;
                repeat (150) @(negedge aclk);
            end
            stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19);
            if ($urandom_range(0, 1) == 0) stall = 0;
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    // Result checking at the rising edge.
    initial begin
        pvt_pkg::result_t want;
        fail_count = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected: %h", m_result);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_result.out_x !== want.out_x) begin
                        $error("out_x expected %0d actual %0d", want.out_x, m_result.out_x);
                        fail_count++;
                    end
                    if (m_result.out_y !== want.out_y) begin
                        $error("out_y expected %0d actual %0d", want.out_y, m_result.out_y);
                        fail_count++;
                    end
                    if (m_result.out_z !== want.out_z) begin
                        $error("out_z expected %0d actual %0d", want.out_z, m_result.out_z);
                        fail_count++;
                    end
                    if (m_result.divide_by_zero !== want.divide_by_zero) begin
                        $error("divide_by_zero expected %0b actual %0b",
                               want.divide_by_zero, m_result.divide_by_zero);
                        fail_count++;
                    end
                end
            end
        end
    end

    // End of run and timeout.
    initial begin
        cycle_count = 0;
        while (!stim_done && cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        if (stim_done) begin
            repeat (LATENCY + 10) @(posedge aclk);
            if (fail_count == 0 && expected_results.size() == 0)
                $display("perspective_vertex_transform: match");
            else
                $display("perspective_vertex_transform: mismatch");
        end else begin
            $display("perspective_vertex_transform: mismatch");
        end
        $finish;
    end

endmodule
